// ===== hdl/cfd_pkg.sv =====
// Shared types and constants of the constant-fraction pulse timing integrator.
// Used by the channel interfaces, the controller, the datapath and the divider.
// No dependencies.
package cfd_pkg;

    localparam int MAX_SAMPLES_DEF = 256;
    localparam int SAMPLE_W        = 14;
    localparam int TS_W            = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int TIME_W          = 48;
    localparam int ENERGY_W        = 48;
    localparam int FULL_W          = 19;
    localparam int TAIL_W          = 18;
    localparam int RATIO_W         = 17;

    // integration window around the peak
    localparam int PRE_SAMPLES  = 4;
    localparam int POST_SAMPLES = 20;
    localparam int TAIL_START   = 5;

    // shared divider and multiplier
    localparam int DIV_NW = 34;
    localparam int DIV_DW = 19;
    localparam int MUL_W  = 33;

    // register reset values
    localparam logic [SAMPLE_W-1:0]   PEDESTAL_RST = '0;
    localparam logic                  POLARITY_RST = 1'b1;
    localparam logic [CFG_DATA_W-1:0] SLOPE_RST    = 32'd65536;
    localparam logic [CFG_DATA_W-1:0] OFFSET_RST   = 32'd0;
    localparam logic [CFG_DATA_W-1:0] TICK_RST     = 32'd655360;
    localparam logic [CFG_DATA_W-1:0] TSHIFT_RST   = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEDESTAL    = 3'd0,
        CFG_POLARITY    = 3'd1,
        CFG_SLOPE       = 3'd2,
        CFG_OFFSET      = 3'd3,
        CFG_CLOCK_TICK  = 3'd4,
        CFG_TIME_SHIFT  = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_SUM_INIT,
        OP_SUM,
        OP_WALK_RD,
        OP_RD_S0,
        OP_RD_S1,
        OP_FRAC_START,
        OP_FRAC_TAKE,
        OP_MAG,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_EN,
        OP_RATIO_START,
        OP_TIME,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic   in_ready;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic scan_last;
        logic sum_last;
        logic j_zero;
        logic beyond;
        logic div_busy;
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== hdl/cfd_if.sv =====
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on cfd_pkg.
interface cfd_in_if;
    logic                          valid;
    logic                          ready;
    logic [cfd_pkg::SAMPLE_W-1:0]  sample;
    logic [cfd_pkg::TS_W-1:0]      island_timestamp;
    logic                          is_last;
    modport source (output valid, sample, island_timestamp, is_last, input ready);
    modport sink   (input valid, sample, island_timestamp, is_last, output ready);
endinterface

interface cfd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [cfd_pkg::SAMPLE_W-1:0]  peak_amplitude;
    logic signed [cfd_pkg::TIME_W-1:0]    pulse_time;
    logic        [cfd_pkg::FULL_W-1:0]    full_integral;
    logic        [cfd_pkg::TAIL_W-1:0]    tail_integral;
    logic signed [cfd_pkg::ENERGY_W-1:0]  pulse_energy;
    logic        [cfd_pkg::RATIO_W-1:0]   tail_ratio;
    logic                                 island_empty;
    modport source (output valid, peak_amplitude, pulse_time, full_integral, tail_integral,
                    pulse_energy, tail_ratio, island_empty, input ready);
    modport sink   (input valid, peak_amplitude, pulse_time, full_integral, tail_integral,
                    pulse_energy, tail_ratio, island_empty, output ready);
endinterface

interface cfd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cfd_pkg::CFG_IDX_W-1:0]   index;
    logic [cfd_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/cfd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the interpolation fraction and the tail ratio. Depends on cfd_pkg.
module cfd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cfd_pkg::DIV_NW-1:0] i_num,
    input  logic [cfd_pkg::DIV_DW-1:0] i_den,
    output logic                       o_busy,
    output logic [cfd_pkg::DIV_NW-1:0] o_quo
);
    import cfd_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   rem_sh;
    logic              ge;
    logic [DIV_DW:0]   rem_sub;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_NW-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operands are held for the whole division
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], ge};
            r_rem <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/cfd_dp.sv =====
// Datapath: island store, registers, peak scan, window sums, crossing walk,
// shared multiplier and divider, output register. Depends on cfd_pkg, cfd_if, cfd_div.
module cfd_dp #(
    parameter int MAX_SAMPLES = cfd_pkg::MAX_SAMPLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfd_pkg::t_dp_cmd i_cmd,
    output cfd_pkg::t_dp_sts o_sts,
    cfd_in_if.sink           i_in,
    cfd_out_if.source        o_out,
    cfd_cfg_if.sink          i_cfg
);
    import cfd_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = AW + 1;

    // registers
    logic        [SAMPLE_W-1:0]   r_ped;
    logic                         r_pos;
    logic signed [CFG_DATA_W-1:0] r_slope;
    logic signed [CFG_DATA_W-1:0] r_offset;
    logic        [CFG_DATA_W-1:0] r_tick;
    logic signed [CFG_DATA_W-1:0] r_tshift;

    // island store and scan state
    logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       r_count;
    logic [TS_W-1:0]     r_ts;
    logic [CW-1:0]       r_idx;
    logic [SAMPLE_W-1:0] r_peak_val;
    logic [AW-1:0]       r_peak_idx;
    logic [FULL_W-1:0]   r_full;
    logic [TAIL_W-1:0]   r_tail;
    logic [AW-1:0]       r_j;
    logic signed [15:0]  r_cf;
    logic [SAMPLE_W-1:0] r_s0;
    logic                r_frac_neg;
    logic                r_frac_ok;
    logic signed [34:0]  r_frac;
    logic                r_xneg;
    logic [49:0]         r_mag;
    logic signed [2*MUL_W-1:0] r_prod;
    logic [39:0]         r_lo_sh;
    logic [58:0]         r_p;
    logic [ENERGY_W-1:0] r_energy;
    logic [TIME_W-1:0]   r_time;
    logic [RATIO_W-1:0]  r_ratio;

    // output register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_o_amp;
    logic [TIME_W-1:0]   r_o_time;
    logic [FULL_W-1:0]   r_o_full;
    logic [TAIL_W-1:0]   r_o_tail;
    logic [ENERGY_W-1:0] r_o_energy;
    logic [RATIO_W-1:0]  r_o_ratio;
    logic                r_o_empty;

    t_dp_op op;
    logic   in_acc;
    logic   room;

    assign op     = i_cmd.op;
    assign in_acc = (op == OP_LOAD);
    assign room   = r_count < CW'(MAX_SAMPLES);

    // register writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ped    <= PEDESTAL_RST;
            r_pos    <= POLARITY_RST;
            r_slope  <= SLOPE_RST;
            r_offset <= OFFSET_RST;
            r_tick   <= TICK_RST;
            r_tshift <= TSHIFT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PEDESTAL:   r_ped    <= i_cfg.data[SAMPLE_W-1:0];
                CFG_POLARITY:   r_pos    <= i_cfg.data[0];
                CFG_SLOPE:      r_slope  <= i_cfg.data;
                CFG_OFFSET:     r_offset <= i_cfg.data;
                CFG_CLOCK_TICK: r_tick   <= i_cfg.data;
                CFG_TIME_SHIFT: r_tshift <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // window bounds around the peak
    logic [CW-1:0] peak_ext;
    logic [CW-1:0] win_lo;
    logic [CW:0]   p_end;
    logic [CW-1:0] win_hi;
    logic [CW-1:0] k_idx;
    logic          in_tail;
    always_comb begin
        peak_ext = {1'b0, r_peak_idx};
        win_lo   = (peak_ext >= CW'(PRE_SAMPLES)) ? peak_ext - CW'(PRE_SAMPLES) : '0;
        p_end    = {2'b0, r_peak_idx} + (CW+1)'(POST_SAMPLES);
        win_hi   = (p_end < {1'b0, r_count}) ? p_end[CW-1:0] : r_count;
        k_idx    = r_idx - 1'b1;
        in_tail  = {1'b0, k_idx} >= ({2'b0, r_peak_idx} + (CW+1)'(TAIL_START));
    end

    // read address per step
    always_comb begin
        case (op)
            OP_SCAN_INIT: rd_addr = '0;
            OP_SUM_INIT:  rd_addr = win_lo[AW-1:0];
            OP_WALK_RD:   rd_addr = r_j - 1'b1;
            OP_RD_S0:     rd_addr = r_j;
            OP_RD_S1:     rd_addr = r_j + 1'b1;
            default:      rd_addr = r_idx[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && room) begin
            mem[r_count[AW-1:0]] <= i_in.sample;
        end
        r_rd_data <= mem[rd_addr];
    end

    // sample arithmetic
    logic signed [14:0] sdiff;
    logic [SAMPLE_W-1:0] sabs;
    logic               better;
    logic signed [15:0] amp_d;
    logic signed [15:0] half_d;
    logic signed [15:0] cf_new;
    logic signed [15:0] s_ext;
    logic               beyond;
    always_comb begin
        sdiff  = $signed({1'b0, r_rd_data}) - $signed({1'b0, r_ped});
        sabs   = sdiff[14] ? SAMPLE_W'(-sdiff) : sdiff[SAMPLE_W-1:0];
        better = r_pos ? (r_rd_data > r_peak_val) : (r_rd_data < r_peak_val);
        amp_d  = $signed({2'b0, r_peak_val}) - $signed({2'b0, r_ped});
        half_d = (amp_d + (amp_d[15] ? 16'sd1 : 16'sd0)) >>> 1;
        if (r_pos) begin
            cf_new = $signed({2'b0, r_ped}) + half_d;
        end else begin
            cf_new = $signed(({2'b0, r_ped} + {2'b0, r_peak_val}) >> 1);
        end
        s_ext  = $signed({2'b0, r_rd_data});
        beyond = r_pos ? (s_ext > r_cf) : (s_ext < r_cf);
    end

    // fraction operands
    logic signed [16:0] num_d;
    logic signed [15:0] den_d;
    logic [15:0]        num_abs;
    logic [14:0]        den_abs;
    logic [CW-1:0]      j_next;
    always_comb begin
        num_d   = $signed({r_cf[15], r_cf}) - $signed({3'b0, r_s0});
        den_d   = $signed({2'b0, r_rd_data}) - $signed({2'b0, r_s0});
        num_abs = num_d[16] ? 16'(-num_d) : num_d[15:0];
        den_abs = den_d[15] ? 15'(-den_d) : den_d[14:0];
        j_next  = {1'b0, r_j} + 1'b1;
    end

    // shared divider
    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_busy;
    logic [DIV_NW-1:0] div_quo;
    always_comb begin
        div_start = (op == OP_FRAC_START) || (op == OP_RATIO_START);
        if (op == OP_FRAC_START) begin
            div_num = DIV_NW'({num_abs, 16'b0});
            div_den = DIV_DW'(den_abs);
        end else begin
            div_num = {r_tail, 16'b0};
            div_den = r_full;
        end
    end

    cfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // crossing position in Q.16 sample units
    logic [32:0]        jts;
    logic signed [50:0] xpos;
    always_comb begin
        jts  = {1'b0, r_ts} + 33'(r_j);
        xpos = $signed({2'b0, jts, 16'b0}) + $signed({{16{r_frac[34]}}, r_frac});
    end

    // shared multiplier, registered product
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod;
    always_comb begin
        case (op)
            OP_MUL_LO: begin
                mul_a = $signed({1'b0, r_mag[31:0]});
                mul_b = $signed({1'b0, r_tick});
            end
            OP_MUL_HI: begin
                mul_a = $signed({15'b0, r_mag[49:32]});
                mul_b = $signed({1'b0, r_tick});
            end
            default: begin
                mul_a = $signed({r_slope[31], r_slope});
                mul_b = $signed({19'b0, r_peak_val});
            end
        endcase
        prod = mul_a * mul_b;
    end

    // signed time with shift and saturation
    logic signed [60:0] p_s;
    logic signed [60:0] t_full;
    logic [TIME_W-1:0]  t_sat;
    always_comb begin
        p_s    = r_xneg ? -$signed({2'b0, r_p}) : $signed({2'b0, r_p});
        t_full = p_s - 61'(r_tshift >>> 8);
        if (t_full > 61'sh7FFF_FFFF_FFFF) begin
            t_sat = 48'h7FFF_FFFF_FFFF;
        end else if (t_full < -61'sh8000_0000_0000) begin
            t_sat = 48'h8000_0000_0000;
        end else begin
            t_sat = t_full[TIME_W-1:0];
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ts        <= '0;
            r_peak_idx  <= '0;
            r_peak_val  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (op)
                OP_LOAD: begin
                    if (r_count == '0) begin
                        r_ts <= i_in.island_timestamp;
                    end
                    if (room) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                OP_SCAN: begin
                    if (r_idx == CW'(1) || better) begin
                        r_peak_val <= r_rd_data;
                        r_peak_idx <= k_idx[AW-1:0];
                    end
                end
                OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_count     <= '0;
                end
                default: ;
            endcase
        end
    end

    // analysis payload
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        case (op)
            OP_SCAN_INIT: r_idx <= CW'(1);
            OP_SCAN:      r_idx <= r_idx + 1'b1;
            OP_SUM_INIT: begin
                r_idx  <= win_lo + 1'b1;
                r_full <= '0;
                r_tail <= '0;
                r_j    <= r_peak_idx;
                r_cf   <= cf_new;
            end
            OP_SUM: begin
                r_idx  <= r_idx + 1'b1;
                r_full <= r_full + FULL_W'(sabs);
                if (in_tail) begin
                    r_tail <= r_tail + TAIL_W'(sabs);
                end
            end
            OP_WALK_RD: r_j <= r_j - 1'b1;
            OP_RD_S1:   r_s0 <= r_rd_data;
            OP_FRAC_START: begin
                r_frac_neg <= num_d[16] ^ den_d[15];
                r_frac_ok  <= (j_next < r_count) && (den_d != '0);
            end
            OP_FRAC_TAKE: begin
                if (r_frac_ok) begin
                    r_frac <= r_frac_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                end else begin
                    r_frac <= '0;
                end
            end
            OP_MAG: begin
                r_xneg <= xpos[50];
                r_mag  <= xpos[50] ? 50'(-xpos) : xpos[49:0];
            end
            OP_MUL_HI: r_lo_sh <= r_prod[63:24];
            OP_MUL_EN: r_p <= {1'b0, r_prod[49:0], 8'b0} + 59'(r_lo_sh);
            OP_RATIO_START: begin
                r_energy <= r_prod[ENERGY_W-1:0] + ENERGY_W'(r_offset);
            end
            // time and ratio are latched here; emit waits while a previous item is still held
            OP_TIME: begin
                r_time  <= t_sat;
                r_ratio <= (r_full == '0) ? '0 : div_quo[RATIO_W-1:0];
            end
            OP_EMIT: begin
                r_o_amp    <= r_peak_val;
                r_o_time   <= r_time;
                r_o_full   <= r_full;
                r_o_tail   <= r_tail;
                r_o_energy <= r_energy;
                r_o_ratio  <= r_ratio;
                r_o_empty  <= (r_count == '0);
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb begin
        o_sts.in_valid  = i_in.valid;
        o_sts.in_last   = i_in.is_last;
        o_sts.scan_last = (r_idx == r_count);
        o_sts.sum_last  = (r_idx == win_hi);
        o_sts.j_zero    = (r_j == '0);
        o_sts.beyond    = beyond;
        o_sts.div_busy  = div_busy;
        o_sts.out_busy  = r_out_valid;
    end

    assign i_in.ready           = i_cmd.in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.peak_amplitude = r_o_amp;
    assign o_out.pulse_time     = r_o_time;
    assign o_out.full_integral  = r_o_full;
    assign o_out.tail_integral  = r_o_tail;
    assign o_out.pulse_energy   = r_o_energy;
    assign o_out.tail_ratio     = r_o_ratio;
    assign o_out.island_empty   = r_o_empty;

endmodule

// ===== hdl/cfd_ctrl.sv =====
// Controller state machine: loads an island, then steps the datapath through
// the analysis of it. Depends on cfd_pkg.
module cfd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfd_pkg::t_dp_sts i_sts,
    output cfd_pkg::t_dp_cmd o_cmd
);
    import cfd_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_SCAN_INIT, S_SCAN, S_SUM_INIT, S_SUM, S_WALK, S_WALK_CHK,
        S_RD_S0, S_RD_S1, S_FRAC_START, S_FRAC_WAIT, S_MAG, S_MUL_LO, S_MUL_HI,
        S_MUL_EN, S_RATIO_START, S_RATIO_WAIT, S_TIME, S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // step command and next state
    always_comb begin
        n_state        = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = OP_IDLE;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_sts.in_last) n_state = S_SCAN_INIT;
                end
            end
            S_SCAN_INIT: begin
                o_cmd.op = OP_SCAN_INIT;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_sts.scan_last) n_state = S_SUM_INIT;
            end
            S_SUM_INIT: begin
                o_cmd.op = OP_SUM_INIT;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                if (i_sts.sum_last) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.j_zero) begin
                    n_state = S_RD_S0;
                end else begin
                    o_cmd.op = OP_WALK_RD;
                    n_state  = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                n_state = i_sts.beyond ? S_WALK : S_RD_S0;
            end
            S_RD_S0: begin
                o_cmd.op = OP_RD_S0;
                n_state  = S_RD_S1;
            end
            S_RD_S1: begin
                o_cmd.op = OP_RD_S1;
                n_state  = S_FRAC_START;
            end
            S_FRAC_START: begin
                o_cmd.op = OP_FRAC_START;
                n_state  = S_FRAC_WAIT;
            end
            S_FRAC_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = OP_FRAC_TAKE;
                    n_state  = S_MAG;
                end
            end
            S_MAG: begin
                o_cmd.op = OP_MAG;
                n_state  = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = S_MUL_EN;
            end
            S_MUL_EN: begin
                o_cmd.op = OP_MUL_EN;
                n_state  = S_RATIO_START;
            end
            S_RATIO_START: begin
                o_cmd.op = OP_RATIO_START;
                n_state  = S_RATIO_WAIT;
            end
            S_RATIO_WAIT: begin
                if (!i_sts.div_busy) n_state = S_TIME;
            end
            S_TIME: begin
                o_cmd.op = OP_TIME;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/pulse_cfd_timing_integrator_core.sv =====
// Constant-fraction pulse timing integrator, top level.
// Depends on cfd_pkg, cfd_if, cfd_ctrl, cfd_dp, cfd_div.
//
// Usage:
//   i_in   carries the samples of one island, one item a cycle while loading;
//          the timestamp is taken from the first item, is_last ends the island.
//   o_out  carries one result item per island.
//   i_cfg  writes the registers (index 0..5); always ready, write while idle.
// Throughput: loading takes one sample per cycle. After the last sample the
//   island is analysed step by step: the peak scan over all n samples, the
//   window sums over up to 24 samples, the walk back to the crossing, then
//   the fixed steps, with two passes through the shared 34-step divider.
//   Input is not accepted during analysis.
// Stall: the result waits in the output register; the next island loads
//   meanwhile, and its analysis holds before emitting until the register frees.
// Reset: registers return to their defaults, the store count clears, no result.
module pulse_cfd_timing_integrator_core #(
    parameter int MAX_SAMPLES = cfd_pkg::MAX_SAMPLES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfd_in_if.sink     i_in,
    cfd_out_if.source  o_out,
    cfd_cfg_if.sink    i_cfg
);
    import cfd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    cfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cfd_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

endmodule
